FILE: rtl/core/byte_ring_fifo_burst_unit_macros.svh
// Assertion helpers; expect clk and rst in scope.
`ifndef BYTE_RING_FIFO_BURST_UNIT_MACROS_SVH
`define BYTE_RING_FIFO_BURST_UNIT_MACROS_SVH

// Same-cycle implication.
`define BRFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/brfb_pkg.sv
package brfb_pkg;

  localparam int LANES      = 8;
  localparam int LANE_W     = 3;
  localparam int SIZE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_GET   = 2'd1;
  localparam logic [1:0] FUNC_INVAL = 2'd2;
  localparam logic [1:0] FUNC_DMA   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_UNDER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_STEP  = 2'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  burst_len;
    logic [63:0] data_in;
  } item_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [8:0]  count;
    logic [1:0]  status;
    logic [8:0]  filled;
    logic [31:0] total_written;
    logic [31:0] total_read;
  } result_t;

endpackage

FILE: rtl/core/brfb_ram.sv
module brfb_ram #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/byte_ring_fifo_burst_unit.sv
// Channel  | Signals                          | Direction
// item     | item_valid, item_stall, item     | in, stall out
// result   | result_valid, result_stall, result | out, stall in
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in, ready out
//
// Put of n bytes: one byte per cycle through the single RAM write port.
// Get of n bytes: one byte per cycle through the registered RAM read port.
// Empty or rejected put, empty get, invalidate: decide, finish; DMA: add, compare, finish.
// Synchronous reset; storage is not cleared and needs no clearing pass.
// item_stall is high while a word is in work; a stalled result waits in its own register.
`include "byte_ring_fifo_burst_unit_macros.svh"

module byte_ring_fifo_burst_unit
  import brfb_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int BURST = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW       = $clog2(DEPTH);
  localparam int DEPTH_LG = $clog2(DEPTH + 1) - 1;
  localparam logic [3:0] LEN_MAX = 4'(BURST);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_PUT, S_GET, S_GET_TAIL, S_DMA, S_FINISH
  } state_t;

  function automatic logic [SIZE_W-1:0] size_of(input logic [3:0] lg);
    logic [3:0] lg_c;
    lg_c = (lg == 4'd0) ? 4'd1 : lg;
    if (int'(lg_c) > DEPTH_LG) begin
      lg_c = 4'(DEPTH_LG);
    end
    return SIZE_W'(1) << lg_c;
  endfunction

  state_t            state;
  logic [1:0]        func_q;
  logic [3:0]        len_q;
  logic [3:0]        n_q;
  logic [63:0]       data_q;
  logic [63:0]       acc;
  logic [LANE_W-1:0] idx;
  logic [LANE_W-1:0] rd_pos;
  logic              rd_pend;
  logic [8:0]        count_q;
  logic [1:0]        status_q;
  logic [31:0]       wc;
  logic [31:0]       rc;
  logic [31:0]       wtot;
  logic [31:0]       rtot;
  logic [31:0]       dpos;
  logic [15:0]       dma_step;
  logic [SIZE_W-1:0] size;
  logic [AW-1:0]     mask;

  logic [31:0]       filled32;
  logic [SIZE_W-1:0] space;
  logic [3:0]        n_next;
  logic [8:0]        filled_sat;
  logic [31:0]       base;
  logic [AW-1:0]     addr;
  logic              idx_last;
  logic [7:0]        rdata;

  assign filled32   = wc - rc;
  assign space      = (filled32 >= {16'b0, size}) ? '0 : size - filled32[SIZE_W-1:0];
  assign n_next     = ({28'b0, len_q} < filled32) ? len_q : filled32[3:0];
  assign filled_sat = (|filled32[31:9]) ? 9'h1FF : filled32[8:0];
  assign base       = (state == S_PUT) ? wc : rc;
  assign addr       = (base[AW-1:0] + AW'(idx)) & mask;
  assign idx_last   = (4'({1'b0, idx}) + 4'd1) == ((state == S_PUT) ? len_q : n_q);

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  brfb_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (state == S_PUT),
    .waddr (addr),
    .wdata (data_q[7:0]),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      rd_pend      <= 1'b0;
      wc           <= '0;
      rc           <= '0;
      wtot         <= '0;
      rtot         <= '0;
      dpos         <= '0;
      dma_step     <= '0;
      size         <= size_of(4'd8);
      mask         <= AW'(size_of(4'd8) - SIZE_W'(1));
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SIZE_LOG2: begin
            size <= size_of(cfg_data[3:0]);
            mask <= AW'(size_of(cfg_data[3:0]) - SIZE_W'(1));
          end
          CFG_DMA_STEP: dma_step <= cfg_data;
          default: ;
        endcase
      end

      if (result_valid && !result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end

      if (rd_pend) begin
        acc[{rd_pos, 3'b000} +: 8] <= rdata;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            func_q   <= item.func;
            len_q    <= (item.burst_len > LEN_MAX) ? LEN_MAX : item.burst_len;
            data_q   <= item.data_in;
            acc      <= '0;
            count_q  <= '0;
            status_q <= STATUS_OK;
            idx      <= '0;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          unique case (func_q)
            FUNC_PUT: begin
              if (len_q == 4'd0) begin
                state <= S_FINISH;
              end else if ({12'b0, len_q} > space) begin
                status_q <= STATUS_FULL;
                state    <= S_FINISH;
              end else begin
                count_q <= space[8:0];
                state   <= S_PUT;
              end
            end
            FUNC_GET: begin
              n_q   <= n_next;
              state <= (n_next == 4'd0) ? S_FINISH : S_GET;
            end
            FUNC_INVAL: begin
              rc    <= wc;
              state <= S_FINISH;
            end
            FUNC_DMA: begin
              dpos  <= dpos + {17'b0, dma_step[15:1]};
              state <= S_DMA;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_PUT: begin
          data_q <= {8'b0, data_q[63:8]};
          idx    <= idx + LANE_W'(1);
          if (idx_last) begin
            wc    <= wc + {28'b0, len_q};
            wtot  <= wtot + {28'b0, len_q};
            state <= S_FINISH;
          end
        end
        S_GET: begin
          rd_pend <= 1'b1;
          rd_pos  <= idx;
          idx     <= idx + LANE_W'(1);
          if (idx_last) begin
            state <= S_GET_TAIL;
          end
        end
        S_GET_TAIL: begin
          rd_pend <= 1'b0;
          rc      <= rc + {28'b0, n_q};
          rtot    <= rtot + {28'b0, n_q};
          count_q <= {5'b0, n_q};
          state   <= S_FINISH;
        end
        S_DMA: begin
          if (dpos < wc) begin
            rc <= dpos;
          end else begin
            rc       <= wc;
            status_q <= STATUS_UNDER;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result.data_out      <= acc;
            result.count         <= count_q;
            result.status        <= status_q;
            result.filled        <= filled_sat;
            result.total_written <= wtot;
            result.total_read    <= rtot;
            result_valid         <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BRFB_ASSERT_NOW(a_put_idx, state == S_PUT, 4'({1'b0, idx}) < len_q, "put lane past burst")
  `BRFB_ASSERT_NEXT(a_busy_after_take, item_valid && !item_stall, state != S_IDLE, "no work after take")
  `BRFB_ASSERT_NOW(a_full_zero, result_valid && result.status == STATUS_FULL, result.count == 9'd0, "rejected put with count")
  `BRFB_ASSERT_NOW(a_rd_pend, rd_pend, state == S_GET || state == S_GET_TAIL, "stray read capture")

endmodule

FILE: tb/byte_ring_fifo_burst_unit_tb.sv
`timescale 1ns / 1ps

module byte_ring_fifo_burst_unit_tb;
  import brfb_pkg::*;

  localparam int DEPTH       = 256;
  localparam int BURST       = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 250;
  localparam int SETTLE      = 12;
  localparam int HOLD_OFF    = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    bit                    typed;
    item_t                 word;
    result_t               want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } plan_row_t;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item_word    = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result_word;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  logic [7:0]  ring_mem  [DEPTH];
  bit          ring_seen [DEPTH];
  logic [31:0] wr_ctr, rd_ctr, bytes_in, bytes_out, dma_at, ring_bytes;
  logic [15:0] dma_len;

  result_t   due_results [$];
  plan_row_t plan [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;

  logic [3:0]  phase_log2 [PHASES] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd4, 4'd8, 4'd2};
  logic [15:0] phase_step [PHASES] = '{16'd0, 16'd2, 16'd16, 16'd7, 16'd1, 16'd32, 16'd24,
                                       16'd65535};

  byte_ring_fifo_burst_unit #(
    .DEPTH(DEPTH),
    .BURST(BURST)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] slot(logic [31:0] ctr);
    return 8'(ctr & (ring_bytes - 32'd1));
  endfunction

  function automatic void set_ring_size(logic [3:0] lg);
    ring_bytes = 32'd1 << ((lg < 4'd1) ? 4'd1 : lg);
    while (ring_bytes > DEPTH) ring_bytes = ring_bytes >> 1;
  endfunction

  function automatic void ring_reset();
    for (int i = 0; i < DEPTH; i++) begin
      ring_mem[i]  = 8'h00;
      ring_seen[i] = 1'b0;
    end
    wr_ctr    = '0;
    rd_ctr    = '0;
    bytes_in  = '0;
    bytes_out = '0;
    dma_at    = '0;
    dma_len   = '0;
    set_ring_size(4'd8);
  endfunction

  function automatic result_t ring_apply(item_t w);
    result_t     r;
    logic [31:0] len, held, space, take;
    r    = '0;
    len  = (w.burst_len > BURST) ? BURST : w.burst_len;
    held = wr_ctr - rd_ctr;
    case (w.func)
      FUNC_PUT: begin
        if (len != 0) begin
          space = (held >= ring_bytes) ? 32'd0 : ring_bytes - held;
          if (len > space) begin
            r.status = STATUS_FULL;
          end else begin
            for (int i = 0; i < len; i++) begin
              ring_mem[slot(wr_ctr + i)]  = w.data_in[8*i +: 8];
              ring_seen[slot(wr_ctr + i)] = 1'b1;
            end
            wr_ctr   += len;
            bytes_in += len;
            r.count  = space[8:0];
          end
        end
      end
      FUNC_GET: begin
        take = (len < held) ? len : held;
        for (int i = 0; i < take; i++)
          r.data_out[8*i +: 8] = ring_mem[slot(rd_ctr + i)];
        rd_ctr    += take;
        bytes_out += take;
        r.count   = take[8:0];
      end
      FUNC_INVAL: begin
        rd_ctr = wr_ctr;
      end
      default: begin
        dma_at += {17'd0, dma_len[15:1]};
        // plain unsigned compare, no wrap handling
        if (dma_at < wr_ctr) begin
          rd_ctr = dma_at;
        end else begin
          rd_ctr   = wr_ctr;
          r.status = STATUS_UNDER;
        end
      end
    endcase
    held            = wr_ctr - rd_ctr;
    r.filled        = (held > 32'd511) ? 9'd511 : held[8:0];
    r.total_written = bytes_in;
    r.total_read    = bytes_out;
    return r;
  endfunction

  function automatic result_t outcome(logic [63:0] dout, logic [8:0] cnt, logic [1:0] st,
                                      logic [8:0] fil, logic [31:0] tw, logic [31:0] tr);
    return {dout, cnt, st, fil, tw, tr};
  endfunction

  function automatic void plan_word(logic [1:0] f, logic [3:0] n, logic [63:0] d,
                                    bit typed = 1'b0, result_t want = '0);
    plan_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.typed = typed;
    r.word  = {f, n, d};
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  task automatic drain(bit settle);
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain(1'b1);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SIZE_LOG2) set_ring_size(val[3:0]);
    else if (idx == CFG_DMA_STEP) dma_len = val;
  endtask

  task automatic send_word(item_t w, bit typed, result_t want);
    logic [31:0] len, held;
    bit          cut;
    result_t     got;
    cut = 1'b0;
    // never read a byte that no put has written
    if (w.func == FUNC_GET) begin
      len  = (w.burst_len > BURST) ? BURST : w.burst_len;
      held = wr_ctr - rd_ctr;
      if (held < len) len = held;
      for (int i = 0; i < len; i++)
        if (!cut && !ring_seen[slot(rd_ctr + i)]) begin
          w.burst_len = 4'(i);
          cut = 1'b1;
        end
    end
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_word  <= w;
    do @(posedge clk); while (!(item_valid && !item_stall));
    got = ring_apply(w);
    due_results.push_back(typed ? want : got);
  endtask

  task automatic show(string tag, result_t r);
    $display("  %s data %h count %0d status %0d filled %0d written %0d read %0d",
             tag, r.data_out, r.count, r.status, r.filled, r.total_written, r.total_read);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result word with nothing outstanding", $time);
          show("got", result_word);
        end
      end else begin
        want = due_results.pop_front();
        if (result_word !== want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: result word mismatch", $time);
            show("exp", want);
            show("got", result_word);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    item_t w;
    int    pick, lsel;
    ring_reset();
    tx_idle_pct = 9;
    rx_idle_pct = 62;

    plan_word(FUNC_GET, 4'd8, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_OK, 9'd0, 32'd0, 32'd0));
    plan_word(FUNC_PUT, 4'd0, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_OK, 9'd0, 32'd0, 32'd0));
    plan_word(FUNC_PUT, 4'd8, 64'h0706_0504_0302_0100, 1'b1,
              outcome(64'h0, 9'd256, STATUS_OK, 9'd8, 32'd8, 32'd0));
    plan_word(FUNC_PUT, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              outcome(64'h0, 9'd248, STATUS_OK, 9'd16, 32'd16, 32'd0));
    plan_word(FUNC_GET, 4'd3, {$urandom, $urandom}, 1'b1,
              outcome(64'h02_0100, 9'd3, STATUS_OK, 9'd13, 32'd16, 32'd3));
    plan_word(FUNC_GET, 4'd15, {$urandom, $urandom}, 1'b1,
              outcome(64'hFFFF_FF07_0605_0403, 9'd8, STATUS_OK, 9'd5, 32'd16, 32'd11));
    plan_word(FUNC_GET, 4'd0, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_OK, 9'd5, 32'd16, 32'd11));
    // zero step: read side moves back to the start
    plan_word(FUNC_DMA, 4'd0, 64'h0, 1'b1,
              outcome(64'h0, 9'd0, STATUS_OK, 9'd16, 32'd16, 32'd11));
    plan_word(FUNC_GET, 4'd8, 64'h0, 1'b1,
              outcome(64'h0706_0504_0302_0100, 9'd8, STATUS_OK, 9'd8, 32'd16, 32'd19));
    plan_word(FUNC_INVAL, 4'd15, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_OK, 9'd0, 32'd16, 32'd19));
    plan_word(FUNC_GET, 4'd4, 64'h0, 1'b1,
              outcome(64'h0, 9'd0, STATUS_OK, 9'd0, 32'd16, 32'd19));
    plan_reg(CFG_SIZE_LOG2, 16'd1);
    plan_word(FUNC_PUT, 4'd2, {16'($urandom), 32'($urandom), 16'hABCD}, 1'b1,
              outcome(64'h0, 9'd2, STATUS_OK, 9'd2, 32'd18, 32'd19));
    plan_word(FUNC_PUT, 4'd1, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_FULL, 9'd2, 32'd18, 32'd19));
    plan_word(FUNC_GET, 4'd8, 64'h0, 1'b1,
              outcome(64'hABCD, 9'd2, STATUS_OK, 9'd0, 32'd18, 32'd21));
    plan_reg(CFG_SIZE_LOG2, 16'hFFF0);
    plan_word(FUNC_PUT, 4'd3, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_FULL, 9'd0, 32'd18, 32'd21));
    plan_reg(CFG_SIZE_LOG2, 16'd15);
    plan_reg(CFG_DMA_STEP, 16'd40);
    plan_word(FUNC_DMA, 4'd8, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_UNDER, 9'd0, 32'd18, 32'd21));
    plan_word(FUNC_PUT, 4'd8, {$urandom, $urandom});
    plan_word(FUNC_PUT, 4'd8, {$urandom, $urandom});
    // shrink below the fill level
    plan_reg(CFG_SIZE_LOG2, 16'd2);
    plan_word(FUNC_PUT, 4'd1, {$urandom, $urandom}, 1'b1,
              outcome(64'h0, 9'd0, STATUS_FULL, 9'd16, 32'd34, 32'd21));
    plan_word(FUNC_GET, 4'd8, 64'h0);
    plan_word(FUNC_INVAL, 4'd0, 64'h0, 1'b1,
              outcome(64'h0, 9'd0, STATUS_OK, 9'd0, 32'd34, 32'd29));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) cfg_write(plan[i].reg_idx, plan[i].reg_val);
      else send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        tx_idle_pct = 9;
        rx_idle_pct = 62;
      end else if (p < 6) begin
        tx_idle_pct = 62;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cfg_write(CFG_SIZE_LOG2, {12'($urandom_range(0, 4095)), phase_log2[p]});
      cfg_write(CFG_DMA_STEP, phase_step[p]);
      if (p == 3) cfg_write(CFG_SPARE, 16'hFFFF);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 1 && k == 120) hold_left = HOLD_OFF;
        if (p == 4 && k == 125) drain(1'b0);
        pick = $urandom_range(0, 99);
        lsel = $urandom_range(0, 19);
        w.func = (pick < 45) ? FUNC_PUT : (pick < 85) ? FUNC_GET :
                 (pick < 92) ? FUNC_INVAL : FUNC_DMA;
        w.burst_len = (lsel == 0) ? 4'd0 :
                      (lsel == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, BURST));
        w.data_in = {$urandom, $urandom};
        send_word(w, 1'b0, '0);
      end
    end

    drain(1'b1);
    if (errors == 0 && due_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/brfb_pkg.sv
rtl/core/brfb_ram.sv
rtl/core/byte_ring_fifo_burst_unit.sv
tb/byte_ring_fifo_burst_unit_tb.sv
